// File: hw/rtl/abcp_pkg.sv
`default_nettype none

package abcp_pkg;

    // Parse position inside the text
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_DUR_START,
        PH_NUM,
        PH_DENOM,
        PH_TIE_CHECK,
        PH_TIE_BAR,
        PH_TIE_NOTE,
        PH_CHORD
    } phase_t;

    // Sequencer steps spent on one item
    typedef enum logic [2:0] {
        SQ_IN,
        SQ_DECODE,
        SQ_DIV,
        SQ_TIE,
        SQ_CHORD_OUT
    } seq_t;

    typedef enum logic [1:0] {
        KIND_NOTE,
        KIND_REST,
        KIND_CHORD,
        KIND_ERROR
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_BYTE,
        ERR_ZERO_DIV,
        ERR_EARLY_END
    } err_t;

    typedef enum logic [2:0] {
        TERM_HOLD,
        TERM_ONE,
        TERM_HALF,
        TERM_NUM,
        TERM_NUM_HALF,
        TERM_DIV
    } term_sel_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_EVENT,
        EMIT_ERROR,
        EMIT_CHORD
    } emit_sel_t;

    // Most chord notes ever stored
    localparam int CHORD_SLOTS = 4;

    typedef struct packed {
        logic eot;
        logic letter;
        logic rest;
        logic open;
        logic close;
        logic slash;
        logic dash;
        logic bar;
        logic digit;
        logic zero;
        logic skip;
    } byte_class_t;

    typedef struct packed {
        byte_class_t cls;
        logic        pend_chord;
        logic        div_busy;
        logic        chord_empty;
        logic        chord_last;
        logic        out_free;
    } dp_status_t;

    typedef struct packed {
        logic      in_load;
        logic      clear;
        logic      start_event;
        kind_t     start_kind;
        logic      chord_add;
        logic      num_load;
        term_sel_t term_sel;
        logic      div_start;
        logic      tie_add;
        emit_sel_t emit;
        err_t      err;
        logic      idx_clr;
        logic      idx_inc;
    } dp_cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/abcp_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle, one-digit divisor.
module abcp_div #(
    parameter int DW = 12
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [3:0]    divisor,
    output logic               busy,
    output logic [DW-1:0]      quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    qd_reg, qd_next;
    logic [3:0]       rem_reg, rem_next;
    logic [3:0]       dvs_reg;
    logic [4:0]       rem_sh;
    logic [4:0]       rem_sub;
    logic             ge;

    assign busy     = (cnt_reg != '0);
    assign quotient = qd_reg;

    always_comb begin
        rem_sh  = {rem_reg, qd_reg[DW-1]};
        ge      = (rem_sh >= {1'b0, dvs_reg});
        rem_sub = rem_sh - {1'b0, dvs_reg};
        rem_next = ge ? rem_sub[3:0] : rem_sh[3:0];
        qd_next  = {qd_reg[DW-2:0], ge};
        cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CNT_W'(DW);
        end else if (busy) begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            qd_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy) begin
            qd_reg  <= qd_next;
            rem_reg <= rem_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/abcp_dp.sv
`default_nettype none

module abcp_dp
    import abcp_pkg::*;
#(
    parameter int FRAC_BITS   = 8,
    parameter int CHORD_DEPTH = 4
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [7:0] in_ch,
    input  wire logic       in_eot,
    input  wire dp_cmd_t    cmd,
    output dp_status_t      st,
    input  wire logic       out_ready,
    output logic            out_valid,
    output logic [1:0]      out_kind,
    output logic [2:0]      out_pitch,
    output logic [2:0]      out_octave,
    output logic [15:0]     out_duration,
    output logic [1:0]      out_err,
    output logic            out_last
);

    localparam int DIV_W = 4 + FRAC_BITS;
    localparam int IDX_W = (CHORD_DEPTH > 1) ? $clog2(CHORD_DEPTH) : 1;

    localparam logic [15:0] DUR_MAX   = 16'hFFFF;
    localparam logic [7:0]  CASE_MASK = 8'd95;
    localparam logic [7:0]  CH_UP_A   = 8'h41;
    localparam logic [7:0]  CH_UP_G   = 8'h47;
    localparam logic [7:0]  CH_LO_A   = 8'h61;
    localparam logic [7:0]  CH_LO_G   = 8'h67;
    localparam logic [7:0]  CH_REST_U = 8'h5A;
    localparam logic [7:0]  CH_REST_L = 8'h7A;
    localparam logic [7:0]  CH_OPEN   = 8'h5B;
    localparam logic [7:0]  CH_CLOSE  = 8'h5D;
    localparam logic [7:0]  CH_SLASH  = 8'h2F;
    localparam logic [7:0]  CH_DASH   = 8'h2D;
    localparam logic [7:0]  CH_BAR    = 8'h7C;
    localparam logic [7:0]  CH_COLON  = 8'h3A;
    localparam logic [7:0]  CH_SPACE  = 8'h20;
    localparam logic [7:0]  CH_TAB    = 8'h09;
    localparam logic [7:0]  CH_NL     = 8'h0A;
    localparam logic [7:0]  CH_ZERO   = 8'h30;
    localparam logic [7:0]  CH_NINE   = 8'h39;
    localparam logic [2:0]  OCT_UPPER = 3'd4;
    localparam logic [2:0]  OCT_LOWER = 3'd5;

    function automatic logic [15:0] sat16(input logic [31:0] v);
        return (v > {16'd0, DUR_MAX}) ? DUR_MAX : v[15:0];
    endfunction

    logic [7:0]       ch_reg;
    logic             eot_reg;
    kind_t            kind_reg;
    logic [3:0]       pitch_reg;
    logic [3:0]       num_reg;
    logic [15:0]      sum_reg;
    logic [15:0]      term_reg;
    logic [2:0]       count_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [3:0]       chord_mem [CHORD_DEPTH];

    logic             valid_reg;
    kind_t            okind_reg;
    logic [2:0]       opitch_reg;
    logic [2:0]       ooct_reg;
    logic [15:0]      odur_reg;
    err_t             oerr_reg;
    logic             olast_reg;

    logic [7:0]       masked_diff;
    logic [3:0]       pitch_code;
    logic [16:0]      sum_wide;
    logic [15:0]      total;
    logic [15:0]      one_unit;
    logic [15:0]      term_next;
    logic             div_busy;
    logic [DIV_W-1:0] div_q;
    logic             chord_last;

    assign chord_last = ((3'(idx_reg) + 3'd1) == count_reg);

    // byte class and status
    always_comb begin
        st.cls.eot    = eot_reg;
        st.cls.letter = ((ch_reg >= CH_LO_A) && (ch_reg <= CH_LO_G))
                     || ((ch_reg >= CH_UP_A) && (ch_reg <= CH_UP_G));
        st.cls.rest   = (ch_reg == CH_REST_L) || (ch_reg == CH_REST_U);
        st.cls.open   = (ch_reg == CH_OPEN);
        st.cls.close  = (ch_reg == CH_CLOSE);
        st.cls.slash  = (ch_reg == CH_SLASH);
        st.cls.dash   = (ch_reg == CH_DASH);
        st.cls.bar    = (ch_reg == CH_BAR);
        st.cls.digit  = (ch_reg >= CH_ZERO) && (ch_reg <= CH_NINE);
        st.cls.zero   = (ch_reg == CH_ZERO);
        st.cls.skip   = (ch_reg == CH_SPACE) || (ch_reg == CH_BAR) || (ch_reg == CH_TAB)
                     || (ch_reg == CH_NL) || (ch_reg == CH_COLON);
        st.pend_chord  = (kind_reg == KIND_CHORD);
        st.div_busy    = div_busy;
        st.chord_empty = (count_reg == 3'd0);
        st.chord_last  = chord_last;
        st.out_free    = !valid_reg || out_ready;
    end

    // letter code in bits 2..0, lower case flag in bit 3
    always_comb begin
        masked_diff = (ch_reg & CASE_MASK) - CH_UP_A;
        pitch_code  = {ch_reg[5], masked_diff[2:0]};
    end

    always_comb begin
        sum_wide = {1'b0, sum_reg} + {1'b0, term_reg};
        total    = sum_wide[16] ? DUR_MAX : sum_wide[15:0];
        one_unit = sat16(32'd1 << FRAC_BITS);
    end

    always_comb begin
        case (cmd.term_sel)
            TERM_ONE:      term_next = one_unit;
            TERM_HALF:     term_next = sat16(32'd1 << (FRAC_BITS - 1));
            TERM_NUM:      term_next = sat16(32'(num_reg) << FRAC_BITS);
            TERM_NUM_HALF: term_next = sat16(32'(num_reg) << (FRAC_BITS - 1));
            TERM_DIV:      term_next = sat16(32'(div_q));
            default:       term_next = term_reg;
        endcase
    end

    abcp_div #(
        .DW(DIV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend ({num_reg, {FRAC_BITS{1'b0}}}),
        .divisor  (ch_reg[3:0]),
        .busy     (div_busy),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            ch_reg  <= in_ch;
            eot_reg <= in_eot;
        end
    end

    // pending event
    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            kind_reg  <= KIND_NOTE;
            pitch_reg <= '0;
            num_reg   <= '0;
            sum_reg   <= '0;
            term_reg  <= one_unit;
        end else if (cmd.start_event) begin
            kind_reg  <= cmd.start_kind;
            pitch_reg <= st.cls.letter ? pitch_code : 4'd0;
            sum_reg   <= '0;
            term_reg  <= one_unit;
        end else if (cmd.tie_add) begin
            sum_reg   <= total;
            term_reg  <= one_unit;
        end else begin
            term_reg  <= term_next;
            if (cmd.num_load) begin
                num_reg <= ch_reg[3:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.clear) begin
            count_reg <= '0;
        end else if (cmd.chord_add && (count_reg < 3'(CHORD_DEPTH))) begin
            count_reg <= count_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.chord_add && (count_reg < 3'(CHORD_DEPTH))) begin
            chord_mem[count_reg[IDX_W-1:0]] <= pitch_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.emit != EMIT_NONE) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.emit)
            EMIT_EVENT: begin
                okind_reg  <= kind_reg;
                opitch_reg <= (kind_reg == KIND_NOTE) ? pitch_reg[2:0] : 3'd0;
                ooct_reg   <= (kind_reg != KIND_NOTE) ? 3'd0
                            : (pitch_reg[3] ? OCT_LOWER : OCT_UPPER);
                odur_reg   <= total;
                oerr_reg   <= ERR_NONE;
                olast_reg  <= 1'b1;
            end
            EMIT_ERROR: begin
                okind_reg  <= KIND_ERROR;
                opitch_reg <= 3'd0;
                ooct_reg   <= 3'd0;
                odur_reg   <= '0;
                oerr_reg   <= cmd.err;
                olast_reg  <= 1'b1;
            end
            EMIT_CHORD: begin
                okind_reg  <= KIND_CHORD;
                opitch_reg <= chord_mem[idx_reg][2:0];
                ooct_reg   <= chord_mem[idx_reg][3] ? OCT_LOWER : OCT_UPPER;
                odur_reg   <= sum_reg;
                oerr_reg   <= ERR_NONE;
                olast_reg  <= chord_last;
            end
            default: ;
        endcase
    end

    assign out_valid    = valid_reg;
    assign out_kind     = okind_reg;
    assign out_pitch    = opitch_reg;
    assign out_octave   = ooct_reg;
    assign out_duration = odur_reg;
    assign out_err      = oerr_reg;
    assign out_last     = olast_reg;

endmodule

`default_nettype wire

// File: hw/rtl/abcp_ctrl.sv
`default_nettype none

module abcp_ctrl
    import abcp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t st,
    output dp_cmd_t         cmd
);

    seq_t        seq_reg, seq_next;
    phase_t      phase_reg, phase_next;
    byte_class_t cls;
    err_t        dec_err;
    logic        tie_emit;
    logic        need_out;
    logic        hold;

    assign cls = st.cls;

    // error raised by the byte in the decode step
    always_comb begin
        dec_err = ERR_NONE;
        if (cls.eot) begin
            if (phase_reg inside {PH_DENOM, PH_TIE_BAR, PH_TIE_NOTE, PH_CHORD}) begin
                dec_err = ERR_EARLY_END;
            end
        end else begin
            case (phase_reg)
                PH_IDLE: begin
                    if (!(cls.letter || cls.rest || cls.open || cls.skip)) begin
                        dec_err = ERR_BYTE;
                    end
                end
                PH_DENOM: begin
                    if (cls.digit && cls.zero) begin
                        dec_err = ERR_ZERO_DIV;
                    end
                end
                PH_CHORD: begin
                    if (!(cls.letter || cls.close)) begin
                        dec_err = ERR_BYTE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        tie_emit = !(!cls.eot && cls.dash) && !st.pend_chord;
        need_out = ((seq_reg == SQ_DECODE) && (dec_err != ERR_NONE))
                || ((seq_reg == SQ_TIE) && tie_emit)
                || (seq_reg == SQ_CHORD_OUT);
        hold     = need_out && !st.out_free;
    end

    // next state
    always_comb begin
        seq_next   = seq_reg;
        phase_next = phase_reg;
        if (!hold) begin
            unique case (seq_reg)
                SQ_IN: begin
                    if (s_tvalid) begin
                        seq_next = SQ_DECODE;
                    end
                end
                SQ_DECODE: begin
                    seq_next = SQ_IN;
                    if (dec_err != ERR_NONE) begin
                        phase_next = PH_IDLE;
                    end else if (cls.eot) begin
                        if (phase_reg inside {PH_DUR_START, PH_NUM, PH_TIE_CHECK}) begin
                            seq_next = SQ_TIE;
                        end
                    end else begin
                        unique case (phase_reg)
                            PH_IDLE: begin
                                if (cls.letter || cls.rest) begin
                                    phase_next = PH_DUR_START;
                                end else if (cls.open) begin
                                    phase_next = PH_CHORD;
                                end
                            end
                            PH_DUR_START: begin
                                if (cls.slash) begin
                                    phase_next = PH_TIE_CHECK;
                                end else if (cls.digit) begin
                                    phase_next = PH_NUM;
                                end else begin
                                    seq_next = SQ_TIE;
                                end
                            end
                            PH_NUM: begin
                                if (cls.slash) begin
                                    phase_next = PH_DENOM;
                                end else begin
                                    seq_next = SQ_TIE;
                                end
                            end
                            PH_DENOM: begin
                                seq_next = cls.digit ? SQ_DIV : SQ_TIE;
                            end
                            PH_TIE_CHECK: begin
                                seq_next = SQ_TIE;
                            end
                            PH_TIE_BAR: begin
                                phase_next = cls.bar ? PH_TIE_NOTE : PH_DUR_START;
                            end
                            PH_TIE_NOTE: begin
                                phase_next = PH_DUR_START;
                            end
                            PH_CHORD: begin
                                if (cls.letter) begin
                                    phase_next = PH_DUR_START;
                                end else if (st.chord_empty) begin
                                    phase_next = PH_IDLE;
                                end else begin
                                    seq_next = SQ_CHORD_OUT;
                                end
                            end
                            default: begin
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
                SQ_DIV: begin
                    if (!st.div_busy) begin
                        phase_next = PH_TIE_CHECK;
                        seq_next   = SQ_IN;
                    end
                end
                SQ_TIE: begin
                    if (!cls.eot && cls.dash) begin
                        phase_next = PH_TIE_BAR;
                        seq_next   = SQ_IN;
                    end else begin
                        // event complete: run the same byte again from the new phase
                        phase_next = st.pend_chord ? PH_CHORD : PH_IDLE;
                        seq_next   = SQ_DECODE;
                    end
                end
                SQ_CHORD_OUT: begin
                    if (st.chord_last) begin
                        phase_next = PH_IDLE;
                        seq_next   = SQ_IN;
                    end
                end
                default: begin
                    seq_next = SQ_IN;
                end
            endcase
        end
    end

    // commands
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (seq_reg)
            SQ_IN: begin
                s_tready    = 1'b1;
                cmd.in_load = s_tvalid;
            end
            SQ_DECODE: begin
                if (!hold) begin
                    if (dec_err != ERR_NONE) begin
                        cmd.emit  = EMIT_ERROR;
                        cmd.err   = dec_err;
                        cmd.clear = 1'b1;
                    end else if (cls.eot) begin
                        if (phase_reg == PH_DUR_START) begin
                            cmd.term_sel = TERM_ONE;
                        end else if (phase_reg == PH_NUM) begin
                            cmd.term_sel = TERM_NUM;
                        end
                    end else begin
                        case (phase_reg)
                            PH_IDLE: begin
                                if (cls.letter) begin
                                    cmd.start_event = 1'b1;
                                    cmd.start_kind  = KIND_NOTE;
                                end else if (cls.rest) begin
                                    cmd.start_event = 1'b1;
                                    cmd.start_kind  = KIND_REST;
                                end else if (cls.open) begin
                                    cmd.clear = 1'b1;
                                end
                            end
                            PH_DUR_START: begin
                                if (cls.slash) begin
                                    cmd.term_sel = TERM_HALF;
                                end else if (cls.digit) begin
                                    cmd.num_load = 1'b1;
                                end else begin
                                    cmd.term_sel = TERM_ONE;
                                end
                            end
                            PH_NUM: begin
                                if (!cls.slash) begin
                                    cmd.term_sel = TERM_NUM;
                                end
                            end
                            PH_DENOM: begin
                                if (cls.digit) begin
                                    cmd.div_start = 1'b1;
                                end else begin
                                    cmd.term_sel = TERM_NUM_HALF;
                                end
                            end
                            PH_CHORD: begin
                                if (cls.letter) begin
                                    cmd.chord_add   = 1'b1;
                                    cmd.start_event = 1'b1;
                                    cmd.start_kind  = KIND_CHORD;
                                end else if (st.chord_empty) begin
                                    cmd.clear = 1'b1;
                                end else begin
                                    cmd.idx_clr = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            SQ_DIV: begin
                if (!st.div_busy) begin
                    cmd.term_sel = TERM_DIV;
                end
            end
            SQ_TIE: begin
                if (!hold) begin
                    if (tie_emit) begin
                        cmd.emit  = EMIT_EVENT;
                        cmd.clear = 1'b1;
                    end else begin
                        // tie or chord note: fold term into the sum
                        cmd.tie_add = 1'b1;
                    end
                end
            end
            SQ_CHORD_OUT: begin
                if (!hold) begin
                    cmd.emit = EMIT_CHORD;
                    if (st.chord_last) begin
                        cmd.clear = 1'b1;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg   <= SQ_IN;
            phase_reg <= PH_IDLE;
        end else begin
            seq_reg   <= seq_next;
            phase_reg <= phase_next;
        end
    end

    a_emit_into_free_reg: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit != EMIT_NONE) |-> st.out_free)
        else $error("result loaded while output register still full");

    a_accept_then_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (seq_reg == SQ_DECODE))
        else $error("accepted item not decoded next cycle");

    a_chord_out_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_reg == SQ_CHORD_OUT) |-> ((phase_reg == PH_CHORD) && !st.chord_empty))
        else $error("chord output outside a nonempty chord");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ((seq_reg == SQ_DIV) && !st.div_busy)
        |=> ((seq_reg == SQ_IN) && (phase_reg == PH_TIE_CHECK)))
        else $error("divide completion did not return to input");

endmodule

`default_nettype wire

// File: hw/rtl/abc_note_event_parser_unit.sv
`default_nettype none

// ABC note event parser. Takes ABC text one byte per input item (s_tdata) or an
// end-of-text marker (s_tuser) and emits note, rest, chord member and error items.
// An event goes out once the following byte (or end of text) shows it is complete;
// durations are unsigned fixed point with DUR_FRAC_BITS fraction bits, saturating
// at 0xFFFF. A chord emits one item per stored note (at most min(MAX_CHORD_NOTES, 4)),
// all with the last parsed duration, tlast on the final one. Errors (unexpected
// byte, zero divisor, early end) give one error item and parsing returns to idle.
// Sequencing: one item at a time through a controller and datapath. Most bytes go
// through an accept step and a decode step; a tie dash adds a tie step, and a byte
// (or end of text) that completes an event adds the tie step and is then parsed
// again from the new phase. A divisor digit runs the bit-serial divider, one
// quotient bit per cycle, before the phase moves on. A chord close emits its stored
// notes one per chord-output step; an empty chord emits nothing. Any cycle that must
// load a result waits while the output register is full and not being taken; the
// next byte is still accepted while a result waits.
module abc_note_event_parser_unit
    import abcp_pkg::*;
#(
    parameter int MAX_CHORD_NOTES = 4,
    parameter int DUR_FRAC_BITS   = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    input  wire logic        s_tuser,   // [0] end_of_text
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [2:0] pitch_letter, [5:3] octave,
                                        // [21:6] duration, [23:22] error_code
    output logic [1:0]       m_tuser,   // [1:0] kind
    output logic             m_tlast    // last
);

    // stored chord notes
    localparam int CHORD_DEPTH = (MAX_CHORD_NOTES < CHORD_SLOTS) ? MAX_CHORD_NOTES
                                                                  : CHORD_SLOTS;

    dp_cmd_t     cmd;
    dp_status_t  st;
    logic [1:0]  out_kind;
    logic [2:0]  out_pitch;
    logic [2:0]  out_octave;
    logic [15:0] out_duration;
    logic [1:0]  out_err;

    abcp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    abcp_dp #(
        .FRAC_BITS   (DUR_FRAC_BITS),
        .CHORD_DEPTH (CHORD_DEPTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_ch        (s_tdata),
        .in_eot       (s_tuser),
        .cmd          (cmd),
        .st           (st),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_kind     (out_kind),
        .out_pitch    (out_pitch),
        .out_octave   (out_octave),
        .out_duration (out_duration),
        .out_err      (out_err),
        .out_last     (m_tlast)
    );

    // result packing, first field in the low bits
    assign m_tdata = {out_err, out_duration, out_octave, out_pitch};
    assign m_tuser = out_kind;

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import abcp_pkg::*;

    // DUT build options, kept at the defaults
    localparam int CHORD_CAP = 4;
    localparam int FRAC_BITS = 8;

    // Stream sizing and run bounds
    localparam int RANDOM_ITEMS = 450;
    localparam int CALM_FROM    = 180;   // no idling on either side in this window
    localparam int CALM_TO      = 260;
    localparam int DRAIN_AT     = 320;   // sender pauses here until all results arrived
    localparam int TAIL_CYCLES  = 40;    // divider + chord unload + a few stalls
    localparam int IDLE_PCT     = 17;
    localparam int MAX_REPORTS  = 10;
    localparam int LONG_TIES    = 30;    // 31 terms of 9 units overflows 0xFFFF

    // One result item, split into its fields
    typedef struct {
        kind_t      kind;
        logic [2:0] letter;
        logic [2:0] octave;
        logic [15:0] dur;
        err_t       err;
        logic       last;
    } parse_result_t;

    // Tracks the parser state, predicts the events each accepted byte produces
    // and checks the events coming out in order.
    class note_event_scoreboard;
        parse_result_t expected_events[$];
        int unsigned   bad_events;

        phase_t        ph;
        kind_t         pend_kind;
        logic [3:0]    pend_pitch;   // [2:0] letter, [3] lower case
        logic [3:0]    num;
        int unsigned   dsum;
        int unsigned   term;
        logic [3:0]    slots[CHORD_SLOTS];
        int unsigned   nchord;

        function new();
            foreach (slots[i]) slots[i] = 4'd0;
            bad_events = 0;
            to_idle();
        endfunction

        function int unsigned clip16(int unsigned v);
            return (v > 32'hFFFF) ? 32'hFFFF : v;
        endfunction

        function int unsigned unit();
            return clip16(32'd1 << FRAC_BITS);
        endfunction

        function int unsigned num_scaled();
            return int'(num) << FRAC_BITS;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "g") || (c >= "A" && c <= "G");
        endfunction

        function bit is_skip(logic [7:0] c);
            return c == " " || c == "|" || c == 8'h09 || c == 8'h0A || c == ":";
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function logic [3:0] pitch_of(logic [7:0] c);
            logic [7:0] t;
            t = (c & 8'h5F) - 8'h41;
            return {c >= "a", t[2:0]};
        endfunction

        function void emit(kind_t k, logic [3:0] p, int unsigned d, err_t e, bit lst);
            parse_result_t r;
            bit with_pitch;
            with_pitch = (k == KIND_NOTE || k == KIND_CHORD);
            r.kind   = k;
            r.letter = with_pitch ? p[2:0] : 3'd0;
            r.octave = with_pitch ? (p[3] ? 3'd5 : 3'd4) : 3'd0;
            r.dur    = d[15:0];
            r.err    = e;
            r.last   = lst;
            expected_events.push_back(r);
        endfunction

        function void to_idle();
            ph         = PH_IDLE;
            pend_kind  = KIND_NOTE;
            pend_pitch = 4'd0;
            num        = 4'd0;
            dsum       = 0;
            term       = unit();
            nchord     = 0;
        endfunction

        function void raise_error(err_t e);
            emit(KIND_ERROR, 4'd0, 0, e, 1'b1);
            to_idle();
        endfunction

        // Duration of the pending note is complete; chord notes go back to the chord.
        function void close_term();
            int unsigned total;
            total = clip16(dsum + term);
            if (pend_kind == KIND_CHORD) begin
                dsum = total;
                term = unit();
                ph   = PH_CHORD;
            end else begin
                emit(pend_kind, pend_pitch, total, ERR_NONE, 1'b1);
                to_idle();
            end
        endfunction

        function void open_event(kind_t k, logic [3:0] p);
            pend_kind  = k;
            pend_pitch = p;
            dsum       = 0;
            term       = unit();
            ph         = PH_DUR_START;
        endfunction

        function void on_idle(logic [7:0] c);
            if (is_letter(c)) begin
                open_event(KIND_NOTE, pitch_of(c));
            end else if (c == "z" || c == "Z") begin
                open_event(KIND_REST, 4'd0);
            end else if (c == "[") begin
                to_idle();
                ph = PH_CHORD;
            end else if (!is_skip(c)) begin
                raise_error(ERR_BYTE);
            end
        endfunction

        function void on_chord(logic [7:0] c);
            int unsigned lim;
            lim = (CHORD_CAP < CHORD_SLOTS) ? CHORD_CAP : CHORD_SLOTS;
            if (is_letter(c)) begin
                if (nchord < lim) begin
                    slots[nchord % CHORD_SLOTS] = pitch_of(c);
                    nchord++;
                end
                open_event(KIND_CHORD, pitch_of(c));
            end else if (c == "]") begin
                for (int unsigned i = 0; i < nchord && i < CHORD_SLOTS; i++)
                    emit(KIND_CHORD, slots[i], dsum, ERR_NONE, i + 1 == nchord);
                to_idle();
            end else begin
                raise_error(ERR_BYTE);
            end
        endfunction

        // A byte that is not a tie dash completes the event and is parsed again.
        function void on_tie_check(logic [7:0] c);
            if (c == "-") begin
                dsum = clip16(dsum + term);
                term = unit();
                ph   = PH_TIE_BAR;
            end else begin
                close_term();
                if (ph == PH_CHORD) on_chord(c);
                else on_idle(c);
            end
        endfunction

        function void on_dur_start(logic [7:0] c);
            if (c == "/") begin
                term = clip16(32'd1 << (FRAC_BITS - 1));
                ph   = PH_TIE_CHECK;
            end else if (is_digit(c)) begin
                num = 4'(c - "0");
                ph  = PH_NUM;
            end else begin
                term = unit();
                on_tie_check(c);
            end
        endfunction

        function void on_num(logic [7:0] c);
            if (c == "/") begin
                ph = PH_DENOM;
            end else begin
                term = clip16(num_scaled());
                on_tie_check(c);
            end
        endfunction

        function void on_denom(logic [7:0] c);
            if (c == "0") begin
                raise_error(ERR_ZERO_DIV);
            end else if (is_digit(c)) begin
                term = clip16(num_scaled() / int'(c - "0"));
                ph   = PH_TIE_CHECK;
            end else begin
                term = clip16(num_scaled() / 2);
                on_tie_check(c);
            end
        endfunction

        function void on_end();
            if (ph == PH_IDLE) begin
                to_idle();
                return;
            end
            if (!(ph inside {PH_DUR_START, PH_NUM, PH_TIE_CHECK})) begin
                raise_error(ERR_EARLY_END);
                return;
            end
            if (ph == PH_DUR_START) term = unit();
            else if (ph == PH_NUM) term = clip16(num_scaled());
            close_term();
            // a chord still open at the end only gets the error
            if (ph == PH_CHORD) raise_error(ERR_EARLY_END);
            else to_idle();
        endfunction

        function void accept_byte(logic [7:0] c, bit eot);
            if (eot) begin
                on_end();
                return;
            end
            case (ph)
                PH_DUR_START: on_dur_start(c);
                PH_NUM:       on_num(c);
                PH_DENOM:     on_denom(c);
                PH_TIE_CHECK: on_tie_check(c);
                PH_TIE_BAR:   ph = (c == "|") ? PH_TIE_NOTE : PH_DUR_START;
                PH_TIE_NOTE:  ph = PH_DUR_START;
                PH_CHORD:     on_chord(c);
                default:      on_idle(c);
            endcase
        endfunction

        function string show(parse_result_t r);
            return $sformatf("kind=%0d letter=%0d oct=%0d dur=0x%04h err=%0d last=%0b",
                             r.kind, r.letter, r.octave, r.dur, r.err, r.last);
        endfunction

        function void check_event(parse_result_t seen);
            parse_result_t want;
            if (expected_events.size() == 0) begin
                bad_events++;
                if (bad_events <= MAX_REPORTS)
                    $display("[%0t] unexpected event: %s", $time, show(seen));
                return;
            end
            want = expected_events.pop_front();
            if (seen.kind !== want.kind || seen.letter !== want.letter ||
                seen.octave !== want.octave || seen.dur !== want.dur ||
                seen.err !== want.err || seen.last !== want.last) begin
                bad_events++;
                if (bad_events <= MAX_REPORTS)
                    $display("[%0t] event mismatch\n  want %s\n  got  %s",
                             $time, show(want), show(seen));
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] ch
    logic        s_tuser  = 1'b0;    // [0] end_of_text
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // [2:0] letter, [5:3] octave, [21:6] dur, [23:22] err
    logic [1:0]  m_tuser;            // [1:0] kind
    logic        m_tlast;

    note_event_scoreboard sb = new();

    int unsigned item_count = 0;     // non-blank bytes, end markers included
    bit          calm       = 1'b0;  // when set, neither side idles

    abc_note_event_parser_unit #(
        .MAX_CHORD_NOTES(CHORD_CAP),
        .DUR_FRAC_BITS  (FRAC_BITS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Result side: random back-pressure, changed on the falling edge only
    always @(negedge aclk) begin
        m_tready = calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Sample on the rising edge; values seen here are the ones the DUT drove
    always @(posedge aclk) begin
        parse_result_t seen;
        if (aresetn && m_tvalid && m_tready) begin
            seen.kind   = kind_t'(m_tuser);
            seen.letter = m_tdata[2:0];
            seen.octave = m_tdata[5:3];
            seen.dur    = m_tdata[21:6];
            seen.err    = err_t'(m_tdata[23:22]);
            seen.last   = m_tlast;
            sb.check_event(seen);
        end
    end

    // Drive one item from a falling edge, hold it until taken, return on a falling edge.
    task automatic push_item(logic [7:0] ch, bit eot);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = ch;
        s_tuser  = eot;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.accept_byte(ch, eot);
        if (eot || !sb.is_skip(ch)) item_count++;
        @(negedge aclk);
    endtask

    // End of text; the data byte is don't-care, so make it random
    task automatic send_end();
        push_item(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) push_item(s[i], 1'b0);
    endtask

    // Hold off the sender until every predicted event has come out
    task automatic wait_for_results();
        s_tvalid = 1'b0;
        @(negedge aclk);
        while (sb.expected_events.size() != 0) @(negedge aclk);
    endtask

    function automatic logic [7:0] pick_letter();
        int unsigned n;
        n = $urandom_range(13);
        return (n < 7) ? 8'("a" + n) : 8'("A" + n - 7);
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'("0" + $urandom_range(9));
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(4))
            0:       return " ";
            1:       return "|";
            2:       return 8'h09;
            3:       return 8'h0A;
            default: return ":";
        endcase
    endfunction

    // Optional length: none, lone slash, n, n/, n/d
    task automatic send_duration();
        case ($urandom_range(9))
            0, 1, 2: ;
            3: push_item("/", 1'b0);
            4, 5: push_item(pick_digit(), 1'b0);
            6: begin
                push_item(pick_digit(), 1'b0);
                push_item("/", 1'b0);
            end
            default: begin
                push_item(pick_digit(), 1'b0);
                push_item("/", 1'b0);
                push_item(pick_digit(), 1'b0);
            end
        endcase
    endtask

    // Note (or rest outside a chord), its length and maybe a few ties
    task automatic send_event(bit in_chord);
        int unsigned ties;
        if (!in_chord && $urandom_range(6) == 0)
            push_item($urandom_range(1) ? "z" : "Z", 1'b0);
        else
            push_item(pick_letter(), 1'b0);
        send_duration();
        ties = ($urandom_range(4) == 0) ? $urandom_range(3, 1) : 0;
        repeat (ties) begin
            push_item("-", 1'b0);
            if ($urandom_range(1)) push_item("|", 1'b0);
            // the tied byte is swallowed whatever it is
            if ($urandom_range(7) == 0) push_item(8'($urandom_range(255)), 1'b0);
            else push_item(pick_letter(), 1'b0);
            send_duration();
        end
    endtask

    // Long tie chain of 9-unit notes, drives the duration sum into saturation
    task automatic send_long_tie();
        push_item(pick_letter(), 1'b0);
        push_item("9", 1'b0);
        repeat (LONG_TIES) begin
            push_item("-", 1'b0);
            push_item(pick_letter(), 1'b0);
            push_item("9", 1'b0);
        end
    endtask

    task automatic send_token();
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(99);
        if (pick < 45) begin
            send_event(1'b0);
        end else if (pick < 63) begin
            // chord, sometimes past the note limit, rarely broken off
            push_item("[", 1'b0);
            n = $urandom_range(6);
            repeat (n) send_event(1'b1);
            if ($urandom_range(19) != 0) push_item("]", 1'b0);
            else push_item(8'($urandom_range(255)), 1'($urandom_range(1)));
        end else if (pick < 71) begin
            push_item(pick_blank(), 1'b0);
        end else if (pick < 81) begin
            push_item(8'($urandom_range(255)), 1'b0);
        end else if (pick < 88) begin
            send_end();
        end else if (pick == 88 && $urandom_range(2) == 0) begin
            send_long_tie();
        end else begin
            // text cut off mid-duration or mid-tie
            push_item(pick_letter(), 1'b0);
            case ($urandom_range(2))
                0: push_item("-", 1'b0);
                1: begin
                    push_item(pick_digit(), 1'b0);
                    push_item("/", 1'b0);
                end
                default: begin
                    push_item("-", 1'b0);
                    push_item("|", 1'b0);
                end
            endcase
            send_end();
        end
    endtask

    initial begin
        bit drained;
        drained = 1'b0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: byte extremes, unknown bytes, digit after lone slash,
        // divide by 7 plus tie over a bar with a junk tied byte flushed at end,
        // zero numerator closed by a chord open, over-full chord, empty chord,
        // end while idle, zero divisor, early end after '/' and in an open chord.
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        send_text("a/3");
        send_text("Z9/7-|Q");
        send_end();
        send_text("g0[aBcDe2]");
        send_text("[]");
        send_end();
        send_text("c3/0");
        send_text("d5/");
        send_end();
        send_text("[");
        send_end();
        wait_for_results();

        // Random: mostly well-formed text with random content, some noise
        item_count = 0;
        send_long_tie();
        while (item_count < RANDOM_ITEMS) begin
            calm = (item_count >= CALM_FROM && item_count < CALM_TO);
            if (!drained && item_count >= DRAIN_AT) begin
                wait_for_results();
                drained = 1'b1;
            end
            send_token();
        end
        calm = 1'b0;

        s_tvalid = 1'b0;
        while (sb.expected_events.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.bad_events == 0 && sb.expected_events.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hang guard, far above the slowest legal run
    initial begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
